// File: sv/sfpmu_pkg.sv
package sfpmu_pkg;

    typedef enum logic [1:0] {
        ACT_WR_DATA = 2'd0,
        ACT_RD_DATA = 2'd1,
        ACT_WR_CMD  = 2'd2,
        ACT_RD_STAT = 2'd3
    } t_action;

    // classified operation
    typedef enum logic [3:0] {
        OP_NOP   = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_MULL  = 4'd3,
        OP_MULH  = 4'd4,
        OP_DIV   = 4'd5,
        OP_CHS   = 4'd6,
        OP_FCHS  = 4'd7,
        OP_DUP   = 4'd8,
        OP_POP   = 4'd9,
        OP_XCH   = 4'd10,
        OP_PI    = 4'd11,
        OP_PUSH  = 4'd12,
        OP_RDD   = 4'd13,
        OP_RDS   = 4'd14
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       wide;   // 32-bit operands
        logic       flt;    // float zero rule
        logic [7:0] data;
    } t_job;

    localparam logic [7:0] FL_CARRY = 8'h01;
    localparam logic [7:0] FL_OVER  = 8'h02;
    localparam logic [7:0] FL_DIV0  = 8'h10;
    localparam logic [7:0] FL_ZERO  = 8'h20;
    localparam logic [7:0] FL_SIGN  = 8'h40;

    localparam logic [7:0] PI_B0 = 8'hDA;
    localparam logic [7:0] PI_B1 = 8'h0F;
    localparam logic [7:0] PI_B2 = 8'hC9;
    localparam logic [7:0] PI_B3 = 8'h02;

    function automatic t_job classify(input logic [1:0] act, input logic [7:0] b);
        t_job       j;
        logic [6:0] c;
        c = b[6:0];
        j.op = OP_NOP;
        j.wide = ~c[6];
        j.flt = 1'b0;
        j.data = b;
        case (t_action'(act))
            ACT_WR_DATA: j.op = OP_PUSH;
            ACT_RD_DATA: j.op = OP_RDD;
            ACT_RD_STAT: j.op = OP_RDS;
            default: begin
                case (c)
                    7'h6C, 7'h2C: j.op = OP_ADD;
                    7'h6D, 7'h2D: j.op = OP_SUB;
                    7'h6E, 7'h2E: j.op = OP_MULL;
                    7'h76, 7'h36: j.op = OP_MULH;
                    7'h6F, 7'h2F: j.op = OP_DIV;
                    7'h74, 7'h34: j.op = OP_CHS;
                    7'h15:        j.op = OP_FCHS;
                    7'h77, 7'h37: j.op = OP_DUP;
                    7'h78, 7'h38: j.op = OP_POP;
                    7'h79, 7'h39: j.op = OP_XCH;
                    7'h17: begin j.op = OP_DUP; j.flt = 1'b1; end
                    7'h18: begin j.op = OP_POP; j.flt = 1'b1; end
                    7'h19: begin j.op = OP_XCH; j.flt = 1'b1; end
                    7'h1A:        j.op = OP_PI;
                    default:      j.op = OP_NOP;
                endcase
            end
        endcase
        return j;
    endfunction

endpackage

// File: sv/sfpmu_front.sv
// Command front: classifies beats and queues them (2 entries).
module sfpmu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_action,
    input  logic [7:0]        i_bus_byte,
    output logic              o_busy,
    output logic              o_valid,
    output sfpmu_pkg::t_job   o_job,
    input  logic              i_take
);
    sfpmu_pkg::t_job r_q [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            acc;

    assign o_busy  = (r_cnt == 2'd2);
    assign acc     = i_start && !o_busy;
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (acc) r_q[r_wp] <= sfpmu_pkg::classify(i_action, i_bus_byte);
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (acc) r_wp <= ~r_wp;
            if (i_take && o_valid) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(acc) - 2'(i_take && o_valid);
        end
    end

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !acc || o_busy == 1'b0) else $error("queue state");
    a_full_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> o_busy) else $error("full without busy");
endmodule

// File: sv/sfpmu_div.sv
// Restoring divider on magnitudes, one quotient bit per cycle.
module sfpmu_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quo
);
    logic [31:0] r_q, r_d;
    logic [32:0] r_r;
    logic [5:0]  r_n;
    logic        r_run;
    logic [32:0] t;
    logic [32:0] sub;

    assign t      = {r_r[31:0], r_q[31]};
    assign sub    = t - {1'b0, r_d};
    assign o_quo  = r_q;
    assign o_done = r_run && (r_n == 6'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_go) begin
            r_run <= 1'b1; r_n <= 6'd32; r_q <= i_num; r_d <= i_den; r_r <= '0;
        end else if (r_run) begin
            if (r_n == 6'd0) begin
                r_run <= 1'b0;
            end else begin
                r_n <= r_n - 6'd1;
                if (!sub[32]) begin
                    r_r <= sub; r_q <= {r_q[30:0], 1'b1};
                end else begin
                    r_r <= t; r_q <= {r_q[30:0], 1'b0};
                end
            end
        end
    end
endmodule

// File: sv/sfpmu_back.sv
// Execution back end: stack, flags, ALU sequencer.
module sfpmu_back #(
    parameter int STACK_BYTES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  sfpmu_pkg::t_job  i_job,
    output logic             o_take,
    output logic             o_strobe,
    output logic [7:0]       o_read_value
);
    localparam int PW = $clog2(STACK_BYTES);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_POPA = 8'b00000010,
        S_POPB = 8'b00000100,
        S_MUL  = 8'b00001000,
        S_DIV  = 8'b00010000,
        S_FIN  = 8'b00100000,
        S_PUSH = 8'b01000000,
        S_MOVE = 8'b10000000
    } t_state;

    t_state          r_st;
    logic [7:0]      r_stk [STACK_BYTES];
    logic [PW-1:0]   r_tp;
    logic [7:0]      r_fl;
    sfpmu_pkg::t_job r_job;
    logic [2:0]      r_k;
    logic [31:0]     r_a, r_b;
    logic [64:0]     r_res;     // exact signed result
    logic [31:0]     r_out;     // bytes to push
    logic [63:0]     r_p;
    logic [7:0]      r_mv [8];  // buffered bytes for dup/xch
    logic            r_strobe;
    logic [7:0]      r_rv;

    logic [2:0]  nb;
    logic [7:0]  top, below;
    logic [31:0] sa, sb;
    logic [31:0] ma, mb;
    logic        dv_go, dv_done;
    logic [31:0] dv_q;
    logic [7:0]  nfl;
    logic signed [63:0] p_lo;
    logic signed [64:0] p_acc, p_hi;

    assign nb    = r_job.wide ? 3'd4 : 3'd2;
    assign top   = r_stk[r_tp];
    assign below = r_stk[r_tp - PW'(1)];
    assign o_take = (r_st == S_IDLE) && i_valid;
    assign o_strobe = r_strobe;
    assign o_read_value = r_rv;

    // sign-extended operands
    assign sa = r_job.wide ? r_a : {{16{r_a[15]}}, r_a[15:0]};
    assign sb = r_job.wide ? r_b : {{16{r_b[15]}}, r_b[15:0]};
    assign ma = sa[31] ? -sa : sa;
    assign mb = sb[31] ? -sb : sb;

    // partial products: a times low half of b, a times signed high half of b
    assign p_lo  = $signed(sa) * $signed({1'b0, sb[15:0]});
    assign p_acc = $signed(r_p);
    assign p_hi  = $signed(sa) * $signed(sb[31:16]);

    sfpmu_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(dv_go),
        .i_num(mb), .i_den(ma), .o_done(dv_done), .o_quo(dv_q)
    );
    assign dv_go = (r_st == S_DIV) && (r_k == 3'd0);

    // exact result and flags
    always_comb begin
        logic signed [64:0] v;
        logic signed [64:0] rng, lim;
        v = $signed(r_res);
        rng = r_job.wide ? 65'sh1_0000_0000 : 65'sh1_0000;
        lim = r_job.wide ? 65'sh8000_0000 : 65'sh8000;
        nfl = 8'h00;
        if (v == 0) nfl = nfl | sfpmu_pkg::FL_ZERO;
        else if (v < 0) nfl = nfl | sfpmu_pkg::FL_SIGN;
        if (v >= rng || v < -rng) nfl = nfl | sfpmu_pkg::FL_OVER;
        if (r_job.op == sfpmu_pkg::OP_ADD || r_job.op == sfpmu_pkg::OP_SUB) begin
            if (v >= 2 * lim || v < -2 * lim)
                nfl = nfl | sfpmu_pkg::FL_OVER | sfpmu_pkg::FL_CARRY;
            else if (v >= lim || v < -lim)
                nfl = (nfl & ~sfpmu_pkg::FL_OVER) | sfpmu_pkg::FL_CARRY;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [7:0] z;
        logic       ng;
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_st <= S_IDLE;
            r_tp <= '0;
            r_fl <= 8'h00;
            for (int i = 0; i < STACK_BYTES; i++) r_stk[i] <= 8'h00;
        end else begin
            r_strobe <= o_take && (i_job.op == sfpmu_pkg::OP_RDD ||
                                   i_job.op == sfpmu_pkg::OP_RDS);
            case (r_st)
                S_IDLE: if (i_valid) begin
                    r_job <= i_job;
                    r_k <= 3'd0;
                    r_a <= '0; r_b <= '0;
                    case (i_job.op)
                        sfpmu_pkg::OP_PUSH: begin
                            r_tp <= r_tp + PW'(1);
                            r_stk[r_tp + PW'(1)] <= i_job.data;
                        end
                        sfpmu_pkg::OP_RDD: begin
                            r_rv <= top; r_tp <= r_tp - PW'(1);
                        end
                        sfpmu_pkg::OP_RDS: r_rv <= r_fl;
                        sfpmu_pkg::OP_NOP: r_fl <= 8'h00;
                        sfpmu_pkg::OP_FCHS: begin
                            if (below[7]) begin
                                r_stk[r_tp] <= top ^ 8'h80;
                                r_fl <= top[7] ? 8'h00 : sfpmu_pkg::FL_SIGN;
                            end else r_fl <= sfpmu_pkg::FL_ZERO;
                        end
                        // pi is a float, so the job is already wide
                        sfpmu_pkg::OP_PI: begin
                            r_fl <= 8'h00; r_out <= {sfpmu_pkg::PI_B3, sfpmu_pkg::PI_B2,
                                                    sfpmu_pkg::PI_B1, sfpmu_pkg::PI_B0};
                            r_st <= S_PUSH;
                        end
                        sfpmu_pkg::OP_POP: begin
                            r_fl <= 8'h00;
                            r_tp <= r_tp - PW'(i_job.op == sfpmu_pkg::OP_POP &&
                                    (i_job.flt || i_job.wide) ? 4 : 2);
                            r_st <= S_FIN;
                        end
                        sfpmu_pkg::OP_DUP, sfpmu_pkg::OP_XCH: begin
                            r_fl <= 8'h00;
                            r_st <= S_MOVE;
                        end
                        default: begin r_fl <= 8'h00; r_st <= S_POPA; end
                    endcase
                end
                S_POPA: begin
                    r_a <= {r_a[23:0], top}; r_tp <= r_tp - PW'(1);
                    if (r_k == nb - 3'd1) begin
                        r_k <= 3'd0;
                        if (r_job.op == sfpmu_pkg::OP_CHS) begin
                            r_st <= S_FIN;
                        end else if (r_job.op == sfpmu_pkg::OP_DIV) begin
                            if ({r_a[23:0], top} == 32'd0 ||
                                (!r_job.wide && {r_a[7:0], top} == 16'd0)) begin
                                r_fl <= sfpmu_pkg::FL_DIV0; r_st <= S_IDLE;
                            end else r_st <= S_POPB;
                        end else r_st <= S_POPB;
                    end else r_k <= r_k + 3'd1;
                end
                S_POPB: begin
                    r_b <= {r_b[23:0], top}; r_tp <= r_tp - PW'(1);
                    if (r_k == nb - 3'd1) begin
                        r_k <= 3'd0;
                        r_st <= (r_job.op == sfpmu_pkg::OP_DIV) ? S_DIV :
                                (r_job.op == sfpmu_pkg::OP_MULL ||
                                 r_job.op == sfpmu_pkg::OP_MULH) ? S_MUL : S_FIN;
                    end else r_k <= r_k + 3'd1;
                end
                S_MUL: begin
                    // 32x32 split into two 16-bit-by-32 partials, low then high
                    if (r_k == 3'd0) begin
                        r_p <= p_lo;
                        r_k <= 3'd1;
                    end else begin
                        r_res <= p_acc + (p_hi <<< 16);
                        r_k <= 3'd2;
                    end
                    if (r_k == 3'd1) r_st <= S_FIN;
                end
                S_DIV: begin
                    if (dv_done && r_k == 3'd1) begin
                        r_res <= (sa[31] ^ sb[31]) ? -{33'd0, dv_q} : {33'd0, dv_q};
                        r_k <= 3'd0;
                        r_st <= S_FIN;
                    end else r_k <= 3'd1;
                end
                S_FIN: begin
                    if (r_job.op == sfpmu_pkg::OP_POP) begin
                        z = top | below;
                        if (r_job.wide || r_job.flt)
                            z = z | r_stk[r_tp - PW'(2)] | r_stk[r_tp - PW'(3)];
                        r_fl <= {1'b0, top[7], r_job.flt ? !below[7] : (z == 8'h00),
                                 5'd0};
                        r_st <= S_IDLE;
                    end else if ((r_job.op == sfpmu_pkg::OP_ADD ||
                                  r_job.op == sfpmu_pkg::OP_SUB ||
                                  r_job.op == sfpmu_pkg::OP_CHS) && r_k == 3'd0) begin
                        // first pass forms the exact sum, difference or negation, second pass flags it
                        r_res <= (r_job.op == sfpmu_pkg::OP_ADD) ?
                                     65'($signed(sb)) + 65'($signed(sa)) :
                                 (r_job.op == sfpmu_pkg::OP_SUB) ?
                                     65'($signed(sb)) - 65'($signed(sa)) :
                                     -65'($signed(sa));
                        r_k <= 3'd1;
                    end else begin
                        if (r_job.op == sfpmu_pkg::OP_MULH) begin
                            r_out <= r_job.wide ? r_res[63:32]
                                                : {r_res[31:16], r_res[31:16]};
                            ng = r_job.wide ? r_res[63] : r_res[31];
                            r_fl <= {1'b0, ng, (r_job.wide ? r_res[63:32] == 32'd0 :
                                     r_res[31:16] == 16'd0), 5'd0};
                        end else begin
                            r_out <= r_res[31:0];
                            r_fl <= nfl;
                        end
                        r_k <= 3'd0;
                        r_st <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    r_tp <= r_tp + PW'(1);
                    r_stk[r_tp + PW'(1)] <= r_out[7:0];
                    r_out <= {8'h00, r_out[31:8]};
                    if (r_k == nb - 3'd1) r_st <= S_IDLE;
                    else r_k <= r_k + 3'd1;
                end
                S_MOVE: begin
                    // phase 0..n-1 reads 2n bytes, then writes
                    if (r_k < 3'(2) * 3'(0) + nb && !r_a[0]) begin
                        r_mv[r_k] <= r_stk[r_tp - PW'(r_k)];
                        r_mv[r_k + nb] <= r_stk[r_tp - PW'(r_k + nb)];
                        if (r_k == nb - 3'd1) begin r_a[0] <= 1'b1; r_k <= 3'd0; end
                        else r_k <= r_k + 3'd1;
                    end else begin
                        if (r_job.op == sfpmu_pkg::OP_DUP)
                            r_stk[r_tp + PW'(nb) - PW'(r_k)] <= r_mv[r_k];
                        else begin
                            r_stk[r_tp - PW'(r_k)] <= r_mv[r_k + nb];
                            r_stk[r_tp - PW'(r_k + nb)] <= r_mv[r_k];
                        end
                        if (r_k == nb - 3'd1) begin
                            if (r_job.op == sfpmu_pkg::OP_DUP) r_tp <= r_tp + PW'(nb);
                            r_job.op <= sfpmu_pkg::OP_POP;
                            r_st <= S_FIN;
                        end else r_k <= r_k + 3'd1;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> r_st == S_IDLE) else $error("take outside idle");
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(o_take)) else $error("strobe without job");
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_st)) else $error("state not one-hot");
endmodule

// File: sv/stack_fixed_point_math_unit.sv
// Stack fixed-point math unit.
// Channel in: start with i_action/i_bus_byte, taken when busy is low.
//   action 0 pushes a byte, 1 pops a byte, 2 runs a command, 3 reads status.
// Channel out: o_strobe marks one cycle carrying o_read_value (pop or status).
//   The receiver cannot stall; every read beat yields one strobe.
// Structure: a front queue (2 beats) classifies beats; the back end owns the
//   operand stack, flags, a two-pass multiplier and a 32-step divider.
// Read path: a read beat is written into the front queue, taken by the back
//   end once it is idle, and its strobe is registered from that take.
//   Push, read and nop finish in the idle state; arithmetic pops operands
//   byte by byte, computes and pushes the result; dup/exchange use a buffer.
// Throughput: one beat in flight in the back end; busy rises once both queue
//   entries wait behind a long command.
// Reset (i_rst_n low, synchronous): stack zero, pointer zero, flags zero,
//   queue empty.
module stack_fixed_point_math_unit #(
    parameter int STACK_BYTES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_action,
    input  logic [7:0] i_bus_byte,
    output logic       o_strobe,
    output logic [7:0] o_read_value
);
    logic            q_valid, q_take;
    sfpmu_pkg::t_job q_job;

    sfpmu_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_action(i_action), .i_bus_byte(i_bus_byte), .o_busy(busy),
        .o_valid(q_valid), .o_job(q_job), .i_take(q_take)
    );

    sfpmu_back #(.STACK_BYTES(STACK_BYTES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_job(q_job),
        .o_take(q_take), .o_strobe(o_strobe), .o_read_value(o_read_value)
    );
endmodule

// File: tb/sv/tb.sv
module tb;

    // Command opcodes, bit 7 clear. The 0x40 bit selects 16-bit operands.
    localparam logic [7:0] OPC_ADD16  = 8'h6C;
    localparam logic [7:0] OPC_ADD32  = 8'h2C;
    localparam logic [7:0] OPC_SUB16  = 8'h6D;
    localparam logic [7:0] OPC_SUB32  = 8'h2D;
    localparam logic [7:0] OPC_MULL16 = 8'h6E;
    localparam logic [7:0] OPC_MULL32 = 8'h2E;
    localparam logic [7:0] OPC_MULH16 = 8'h76;
    localparam logic [7:0] OPC_MULH32 = 8'h36;
    localparam logic [7:0] OPC_DIV16  = 8'h6F;
    localparam logic [7:0] OPC_DIV32  = 8'h2F;
    localparam logic [7:0] OPC_CHS16  = 8'h74;
    localparam logic [7:0] OPC_CHS32  = 8'h34;
    localparam logic [7:0] OPC_FCHS   = 8'h15;
    localparam logic [7:0] OPC_DUP16  = 8'h77;
    localparam logic [7:0] OPC_DUP32  = 8'h37;
    localparam logic [7:0] OPC_FDUP   = 8'h17;
    localparam logic [7:0] OPC_POP16  = 8'h78;
    localparam logic [7:0] OPC_POP32  = 8'h38;
    localparam logic [7:0] OPC_FPOP   = 8'h18;
    localparam logic [7:0] OPC_XCH16  = 8'h79;
    localparam logic [7:0] OPC_XCH32  = 8'h39;
    localparam logic [7:0] OPC_FXCH   = 8'h19;
    localparam logic [7:0] OPC_PI     = 8'h1A;
    localparam logic [7:0] OPC_FADD   = 8'h10;   // float add, treated as no-op

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 900000;
    localparam int DRAIN       = 80;            // > divide latency

    logic [7:0] cmd_list [23] = '{OPC_ADD16, OPC_ADD32, OPC_SUB16, OPC_SUB32,
        OPC_MULL16, OPC_MULL32, OPC_MULH16, OPC_MULH32, OPC_DIV16, OPC_DIV32,
        OPC_CHS16, OPC_CHS32, OPC_FCHS, OPC_DUP16, OPC_DUP32, OPC_FDUP,
        OPC_POP16, OPC_POP32, OPC_FPOP, OPC_XCH16, OPC_XCH32, OPC_FXCH, OPC_PI};

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [1:0] i_action = '0;
    logic [7:0] i_bus_byte = '0;
    logic       o_strobe;
    logic [7:0] o_read_value;

    stack_fixed_point_math_unit #(.STACK_BYTES(DEPTH)) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_bus_byte   (i_bus_byte),
        .o_strobe     (o_strobe),
        .o_read_value (o_read_value)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the unit's state
    logic [7:0] shadow_stack [DEPTH];
    int         shadow_top;
    logic [7:0] shadow_flags;
    logic [7:0] read_q [$];          // bytes expected back, oldest first

    int  errors = 0;
    int  cycles = 0;
    int  burst_left = 0;
    logic [7:0] want;

    // ---------------- predictor ----------------
    function automatic int slot_at(int d);
        return (shadow_top + 2 * DEPTH - d) % DEPTH;
    endfunction

    function automatic void push_b(logic [7:0] b);
        shadow_top = slot_at(-1);
        shadow_stack[shadow_top] = b;
    endfunction

    function automatic logic [7:0] pop_b();
        logic [7:0] b;
        b = shadow_stack[shadow_top];
        shadow_top = slot_at(1);
        return b;
    endfunction

    // Pops n bytes, MSB on top, and sign-extends.
    function automatic longint pop_word(int n);
        longint u;
        u = 0;
        for (int k = 0; k < n; k++) u = (u << 8) | pop_b();
        if (u[8*n-1]) u = u - (longint'(1) << (8 * n));
        return u;
    endfunction

    function automatic void push_word(longint v, int n);
        longint range;
        range = longint'(1) << (8 * n);
        if (v == 0) shadow_flags |= sfpmu_pkg::FL_ZERO;
        else if (v < 0) shadow_flags |= sfpmu_pkg::FL_SIGN;
        if (v >= range || v < -range) shadow_flags |= sfpmu_pkg::FL_OVER;
        for (int k = 0; k < n; k++) push_b(8'(v >> (8 * k)));
    endfunction

    function automatic void carry_flags(longint v, int n);
        longint lim;
        lim = longint'(1) << (8 * n - 1);
        if (v >= 2 * lim || v < -2 * lim) begin
            shadow_flags |= sfpmu_pkg::FL_OVER | sfpmu_pkg::FL_CARRY;
        end else if (v >= lim || v < -lim) begin
            shadow_flags &= ~sfpmu_pkg::FL_OVER;
            shadow_flags |= sfpmu_pkg::FL_CARRY;
        end
    endfunction

    function automatic void fixed_sz(int n);
        logic [7:0] any;
        any = '0;
        if (shadow_stack[slot_at(0)][7]) shadow_flags |= sfpmu_pkg::FL_SIGN;
        for (int k = 0; k < n; k++) any |= shadow_stack[slot_at(k)];
        if (any == 0) shadow_flags |= sfpmu_pkg::FL_ZERO;
    endfunction

    function automatic void float_sz();
        if (shadow_stack[slot_at(0)][7]) shadow_flags |= sfpmu_pkg::FL_SIGN;
        if (!shadow_stack[slot_at(1)][7]) shadow_flags |= sfpmu_pkg::FL_ZERO;
    endfunction

    function automatic void run_cmd(logic [7:0] cmd);
        logic [7:0] op, t;
        int n, a1, b1;
        longint a, b, p, h;
        bit flt;
        op = {1'b0, cmd[6:0]};
        n = op[6] ? 2 : 4;
        shadow_flags = '0;
        case (op)
            OPC_ADD16, OPC_ADD32, OPC_SUB16, OPC_SUB32: begin
                a = pop_word(n);
                b = pop_word(n);
                p = (op == OPC_ADD16 || op == OPC_ADD32) ? b + a : b - a;
                push_word(p, n);
                carry_flags(p, n);
            end
            OPC_MULL16, OPC_MULL32, OPC_MULH16, OPC_MULH32: begin
                a = pop_word(n);
                b = pop_word(n);
                p = a * b;
                if (op == OPC_MULH16 || op == OPC_MULH32) begin
                    h = (p >> (8 * n)) & ((longint'(1) << (8 * n)) - 1);
                    if (h[8*n-1]) h = h - (longint'(1) << (8 * n));
                    p = h;
                end
                push_word(p, n);
            end
            OPC_DIV16, OPC_DIV32: begin
                a = pop_word(n);
                if (a != 0) begin
                    b = pop_word(n);
                    push_word(b / a, n);
                end else begin
                    shadow_flags |= sfpmu_pkg::FL_DIV0;  // dividend stays on top
                end
            end
            OPC_CHS16, OPC_CHS32: begin
                a = pop_word(n);
                push_word(-a, n);
            end
            OPC_FCHS: begin
                if (shadow_stack[slot_at(1)][7]) begin
                    shadow_stack[shadow_top][7] = ~shadow_stack[shadow_top][7];
                    if (shadow_stack[shadow_top][7]) shadow_flags |= sfpmu_pkg::FL_SIGN;
                end else begin
                    shadow_flags |= sfpmu_pkg::FL_ZERO;
                end
            end
            OPC_DUP16, OPC_DUP32, OPC_FDUP: begin
                flt = (op == OPC_FDUP);
                if (flt) n = 4;
                shadow_top = slot_at(-n);
                for (int k = 0; k < n; k++)
                    shadow_stack[slot_at(k)] = shadow_stack[slot_at(k + n)];
                if (flt) float_sz(); else fixed_sz(n);
            end
            OPC_POP16, OPC_POP32, OPC_FPOP: begin
                flt = (op == OPC_FPOP);
                if (flt) n = 4;
                shadow_top = slot_at(n);
                if (flt) float_sz(); else fixed_sz(n);
            end
            OPC_XCH16, OPC_XCH32, OPC_FXCH: begin
                flt = (op == OPC_FXCH);
                if (flt) n = 4;
                for (int k = 0; k < n; k++) begin
                    a1 = slot_at(k);
                    b1 = slot_at(k + n);
                    t = shadow_stack[a1];
                    shadow_stack[a1] = shadow_stack[b1];
                    shadow_stack[b1] = t;
                end
                if (flt) float_sz(); else fixed_sz(n);
            end
            OPC_PI: begin
                push_b(sfpmu_pkg::PI_B0);
                push_b(sfpmu_pkg::PI_B1);
                push_b(sfpmu_pkg::PI_B2);
                push_b(sfpmu_pkg::PI_B3);
            end
            default: ;
        endcase
    endfunction

    function automatic void model_beat(sfpmu_pkg::t_action act, logic [7:0] b);
        case (act)
            sfpmu_pkg::ACT_WR_DATA: push_b(b);
            sfpmu_pkg::ACT_RD_DATA: read_q.push_back(pop_b());
            sfpmu_pkg::ACT_WR_CMD:  run_cmd(b);
            default:                read_q.push_back(shadow_flags);
        endcase
    endfunction

    // ---------------- driver ----------------
    // One beat; the sender runs in bursts with random idle gaps between them.
    task automatic send(sfpmu_pkg::t_action act, logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 9);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        start      <= 1'b1;
        i_action   <= act;
        i_bus_byte <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        model_beat(act, b);
    endtask

    task automatic push_seq(logic [31:0] v, int n);
        for (int k = 0; k < n; k++) send(sfpmu_pkg::ACT_WR_DATA, v[8*k +: 8]);
    endtask

    task automatic cmd_stat(logic [7:0] cmd);
        send(sfpmu_pkg::ACT_WR_CMD, cmd);
        send(sfpmu_pkg::ACT_RD_STAT, 8'h00);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h7F;
            3: return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    // ---------------- checker ----------------
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_strobe) begin
            if (read_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected read beat, exp none got %h", $time,
                         o_read_value);
            end else begin
                want = read_q.pop_front();
                if (o_read_value !== want) begin
                    errors++;
                    $display("%0t: read_value exp %h got %h", $time, want, o_read_value);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------- tests ----------------
    // Push/pop extremes, circular wrap of the pointer, reset status.
    task automatic test_data_path();
        send(sfpmu_pkg::ACT_RD_STAT, 8'h00);
        send(sfpmu_pkg::ACT_RD_DATA, 8'h00);       // pop of an empty stack wraps
        send(sfpmu_pkg::ACT_WR_DATA, 8'hFF);
        send(sfpmu_pkg::ACT_WR_DATA, 8'h00);
        send(sfpmu_pkg::ACT_RD_DATA, 8'h00);
        send(sfpmu_pkg::ACT_RD_DATA, 8'h00);
    endtask

    // 16-bit add hitting twice the limit: carry set, overflow clear.
    task automatic test_add_carry();
        push_seq(32'h8000, 2);
        push_seq(32'h8000, 2);
        cmd_stat(OPC_ADD16);
    endtask

    // Most negative 32-bit value divided by minus one.
    task automatic test_div_edge();
        push_seq(32'h8000_0000, 4);
        push_seq(32'hFFFF_FFFF, 4);
        cmd_stat(OPC_DIV32 | 8'h80);    // bit 7 ignored
    endtask

    // Divide by zero leaves the dividend on top.
    task automatic test_div_zero();
        push_seq(32'h0000, 2);
        cmd_stat(OPC_DIV16);
        send(sfpmu_pkg::ACT_RD_DATA, 8'h00);
    endtask

    // Pi push, float sign change on the sign-flip path, unknown opcode, float dup.
    task automatic test_float_ops();
        send(sfpmu_pkg::ACT_WR_CMD, OPC_PI);
        cmd_stat(OPC_FCHS);
        cmd_stat(OPC_FADD);
        send(sfpmu_pkg::ACT_WR_CMD, OPC_FDUP);
    endtask

    task automatic test_random(int beats);
        int n, left, nrd;
        bit zdiv;
        logic [7:0] cmd;
        left = beats;
        while (left > 0) begin
            if ($urandom_range(0, 6) == 0) begin
                // noise: any action, any byte
                send(sfpmu_pkg::t_action'($urandom_range(0, 3)), 8'($urandom));
                left--;
            end else begin
                cmd = cmd_list[$urandom_range(0, 22)];
                if ($urandom_range(0, 9) == 0) cmd = 8'($urandom);
                n = cmd[6] ? 2 : 4;
                zdiv = ($urandom_range(0, 9) == 0);
                for (int k = 0; k < 2 * n; k++) begin
                    // top operand (divisor) sometimes all zero
                    if (k >= n && zdiv) send(sfpmu_pkg::ACT_WR_DATA, 8'h00);
                    else send(sfpmu_pkg::ACT_WR_DATA, pick_byte());
                end
                send(sfpmu_pkg::ACT_WR_CMD, cmd | ($urandom_range(0, 1) ? 8'h80 : 8'h00));
                send(sfpmu_pkg::ACT_RD_STAT, 8'($urandom));
                nrd = $urandom_range(0, n);
                for (int k = 0; k < nrd; k++)
                    send(sfpmu_pkg::ACT_RD_DATA, 8'($urandom));
                left -= 2 * n + 2 + nrd;
            end
        end
    endtask

    initial begin
        for (int k = 0; k < DEPTH; k++) shadow_stack[k] = '0;
        shadow_top   = 0;
        shadow_flags = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_data_path();
        test_add_carry();
        test_div_edge();
        test_div_zero();
        test_float_ops();
        test_random(1550);

        start <= 1'b0;
        @(posedge i_clk);
        while (read_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
